// ===== rtl/besc_pkg.sv =====
package besc_pkg;

	localparam int ROWS           = 16;
	localparam int GROUPS_PER_ROW = 4;
	localparam int SLICE_BITS     = 32;
	localparam int GROUP_COUNT    = ROWS * GROUPS_PER_ROW;
	localparam int STORE_WORDS    = GROUP_COUNT * SLICE_BITS;

	// field widths fixed by the item format
	localparam int DATA_W  = 32;
	localparam int INDEX_W = 11;
	localparam int SLICE_W = 5;
	localparam int GROUP_W = INDEX_W - SLICE_W;
	localparam int ADDR_W  = INDEX_W;

	localparam logic [SLICE_W-1:0] SLICE_MAX  = SLICE_W'(SLICE_BITS - 1);
	localparam logic [GROUP_W-1:0] GROUP_LAST = GROUP_W'(GROUP_COUNT - 1);
	localparam logic [ADDR_W-1:0]  ADDR_LAST  = ADDR_W'(STORE_WORDS - 1);
	localparam logic [DATA_W-1:0]  ALL_ONES   = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0]  TOP_BIT    = 32'h8000_0000;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_SEARCH
	} state_t;

	typedef struct packed {
		logic              valid;
		logic              first;
		logic              load;
		logic              data_bit;
		logic [DATA_W-1:0] pos_mask;
	} slice_ctrl_t;

endpackage

// ===== rtl/besc_store.sv =====
module besc_store
	import besc_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [STORE_WORDS];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/besc_slice_unit.sv =====
module besc_slice_unit
	import besc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  slice_ctrl_t       ctrl,
	input  logic [DATA_W-1:0] rdata,
	output logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] mask
);

	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] acc_d;
	logic [DATA_W-1:0] query_word;

	assign query_word = {DATA_W{ctrl.data_bit}};

	// running AND of slice XNOR query bit; restarts at the first slice of a group
	assign acc_d = (ctrl.first ? ALL_ONES : acc_q) & ~(rdata ^ query_word);
	assign mask  = acc_d;

	// read-modify-write merge for a load: replace one position's bit
	assign wdata = ctrl.data_bit ? (rdata | ctrl.pos_mask) : (rdata & ~ctrl.pos_mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= ALL_ONES;
		end else if (ctrl.valid && !ctrl.load) begin
			acc_q <= acc_d;
		end
	end

endmodule

// ===== rtl/bit_sliced_equality_scan.sv =====
// Bit-sliced equality scan: a table of 2048 32-bit values held as 64 groups
// of 32 bit-slice words in one single-port-write, registered-read memory.
// Input channel s_axis: tuser selects load (0) or search (1); tdata carries
// the table index and the value. Output channel m_axis: one item per group on
// a search, group 0 upward, tlast on group 63. A load produces no item.
// One item at a time: s_axis_tready is high only while the sequencer is idle.
// A load is a read-modify-write over the 32 slices of its group, one slice a
// cycle. A search reads all 2048 slice words through the memory read port,
// one a cycle while the scan is not paused for the result register, and ANDs
// them in the shared slice unit. Every 11-bit index falls within the table,
// so every load is carried out. After reset the sequencer clears all 2048
// memory words, one word a cycle, before it takes the first item. The result
// register holds while m_axis_tready is low; the scan pauses before finishing
// a group whose result has nowhere to go, so nothing is lost.
module bit_sliced_equality_scan
	import besc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // value_index[10:0], data_value[42:11], zero pad
	input  logic [0:0]  s_axis_tuser,  // req_type[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // group_index[5:0], match_mask[37:6], zero pad
	output logic        m_axis_tlast
);

	state_t state_q, state_d;

	logic [ADDR_W-1:0]  clr_q;
	logic [SLICE_W-1:0] slice_q;
	logic [GROUP_W-1:0] group_q;
	logic               issue_done_q;
	logic [DATA_W-1:0]  val_q;
	logic [SLICE_W-1:0] pos_q;

	logic               rd_valid_s1;
	logic [SLICE_W-1:0] rd_slice_s1;
	logic [GROUP_W-1:0] rd_group_s1;

	logic               out_valid_q;
	logic [GROUP_W-1:0] out_group_q;
	logic [DATA_W-1:0]  out_mask_q;
	logic               out_last_q;

	logic               accept;
	logic               issue;
	logic               slice_end_s1;
	logic               group_done;
	logic               in_req;
	logic [INDEX_W-1:0] in_index;
	logic [DATA_W-1:0]  in_value;

	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic [DATA_W-1:0]  wdata_mux;
	logic [ADDR_W-1:0]  raddr;
	logic [DATA_W-1:0]  rdata;
	logic [DATA_W-1:0]  merge_word;
	logic [DATA_W-1:0]  mask;
	slice_ctrl_t        ctrl;

	assign in_req   = s_axis_tuser[0];
	assign in_index = s_axis_tdata[INDEX_W-1:0];
	assign in_value = s_axis_tdata[INDEX_W +: DATA_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign slice_end_s1 = rd_valid_s1 && (rd_slice_s1 == SLICE_MAX);
	assign group_done   = (state_q == ST_SEARCH) && slice_end_s1;

	// hold back the last slice of a group until the result register is free
	always_comb begin
		issue = 1'b0;
		case (state_q)
			ST_LOAD:   issue = !issue_done_q;
			ST_SEARCH: issue = !issue_done_q && !((slice_q == SLICE_MAX) && out_valid_q);
			default:   issue = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (in_req == REQ_SEARCH) begin
						state_d = ST_SEARCH;
					end else if (int'(in_index[INDEX_W-1:SLICE_W]) < GROUP_COUNT) begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				if (slice_end_s1) state_d = ST_IDLE;
			end
			ST_SEARCH: begin
				if (slice_end_s1 && (rd_group_s1 == GROUP_LAST)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			slice_q      <= '0;
			group_q      <= '0;
			issue_done_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				slice_q      <= '0;
				issue_done_q <= 1'b0;
				group_q      <= (in_req == REQ_SEARCH) ? '0 : in_index[INDEX_W-1:SLICE_W];
			end else if (issue) begin
				slice_q <= slice_q + 1'b1;
				if (slice_q == SLICE_MAX) begin
					if ((state_q == ST_LOAD) || (group_q == GROUP_LAST)) begin
						issue_done_q <= 1'b1;
					end else begin
						group_q <= group_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_slice_s1 <= slice_q;
		rd_group_s1 <= group_q;
		if (accept) begin
			val_q <= in_value;
			pos_q <= in_index[SLICE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (group_done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (group_done) begin
			out_group_q <= rd_group_s1;
			out_mask_q  <= mask;
			out_last_q  <= (rd_group_s1 == GROUP_LAST);
		end
	end

	assign ctrl.valid    = rd_valid_s1;
	assign ctrl.first    = (rd_slice_s1 == '0);
	assign ctrl.load     = (state_q == ST_LOAD);
	assign ctrl.data_bit = val_q[SLICE_MAX - rd_slice_s1];
	assign ctrl.pos_mask = TOP_BIT >> pos_q;

	assign raddr = {group_q, slice_q};

	always_comb begin
		we        = 1'b0;
		waddr     = {rd_group_s1, rd_slice_s1};
		wdata_mux = merge_word;
		case (state_q)
			ST_CLEAR: begin
				we        = 1'b1;
				waddr     = clr_q;
				wdata_mux = '0;
			end
			ST_LOAD: begin
				we = rd_valid_s1;
			end
			default: we = 1'b0;
		endcase
	end

	besc_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata_mux),
		.raddr (raddr),
		.rdata (rdata)
	);

	besc_slice_unit u_slice_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.rdata  (rdata),
		.wdata  (merge_word),
		.mask   (mask)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_mask_q, out_group_q};
	assign m_axis_tlast  = out_last_q;

endmodule
